// ----- src/edfs_pkg.sv -----
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared types and constants for the EDF periodic task scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

  localparam int TASK_SLOTS = 4;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int TIME_W     = 32;
  localparam int HALF_W     = 16;
  localparam int CNT_W      = 3;
  localparam int NUM_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SETUP_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_FIRST = 3'd1;

  localparam logic [CNT_W-1:0]  ACTIVE_CNT_RESET = 3'd1;
  localparam logic [HALF_W-1:0] PERIOD_RESET     = 16'd1;

  localparam logic [TIME_W-1:0] KEY_BIAS = 32'h8000_0000;

  typedef struct packed {
    logic [HALF_W-1:0] period;
    logic [HALF_W-1:0] exec;
  } setup_t;

  typedef struct packed {
    logic [TASK_SLOTS-1:0]          enable;
    setup_t [TASK_SLOTS-1:0]        setup;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              busy;
    logic [NUM_W-1:0]  task_number;
    logic [TIME_W-1:0] task_deadline;
  } result_t;

endpackage

// ----- src/edfs_cfg.sv -----
// ----------------------------------------------------------------------------
// edfs_cfg
// Configuration registers: task count and per-task period/execution setup.
// ----------------------------------------------------------------------------
module edfs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [edfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [edfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output edfs_pkg::cfg_t                    cfg
);

  logic [edfs_pkg::CNT_W-1:0]                   active_cnt;
  edfs_pkg::setup_t [edfs_pkg::TASK_SLOTS-1:0]  setup;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cnt <= edfs_pkg::ACTIVE_CNT_RESET;
      for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) begin
        setup[i].period <= edfs_pkg::PERIOD_RESET;
        setup[i].exec   <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == edfs_pkg::REG_ACTIVE_CNT) begin
        active_cnt <= cfg_data[edfs_pkg::CNT_W-1:0];
      end
      for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) begin
        if (i < edfs_pkg::SETUP_REGS &&
            cfg_index == edfs_pkg::CFG_IDX_W'(int'(edfs_pkg::REG_SETUP_FIRST) + i)) begin
          setup[i] <= edfs_pkg::setup_t'(cfg_data);
        end
      end
    end
  end

  // counts above the slot count saturate naturally
  always_comb begin
    for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) begin
      cfg.enable[i] = (int'(active_cnt) > i);
    end
    cfg.setup = setup;
  end

endmodule

// ----- src/edfs_core.sv -----
// ----------------------------------------------------------------------------
// edfs_core
// Scheduler state (time, phases, budgets, deadlines), job release and
// earliest-deadline pick; state advances on every tick transfer.
// ----------------------------------------------------------------------------
module edfs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              restart,
  input  edfs_pkg::cfg_t    cfg,
  output edfs_pkg::result_t res
);

  localparam int N = edfs_pkg::TASK_SLOTS;
  localparam int TW = edfs_pkg::TIME_W;
  localparam int HW = edfs_pkg::HALF_W;

  logic [TW-1:0]         current_time;
  logic [HW-1:0]         release_phase [N];
  logic [HW-1:0]         budget_left   [N];
  logic [TW-1:0]         job_deadline  [N];

  logic [TW-1:0]         current_time_next;
  logic [HW-1:0]         release_phase_next [N];
  logic [HW-1:0]         budget_left_next   [N];
  logic [TW-1:0]         job_deadline_next  [N];

  logic [TW-1:0]         now;
  logic [HW-1:0]         phase   [N];
  logic [HW-1:0]         period  [N];
  logic [HW-1:0]         bud     [N];
  logic [TW-1:0]         dl      [N];
  logic [TW-1:0]         key     [N];
  logic [HW:0]           phase_inc [N];
  logic [N-1:0]          cand;
  logic                  found;
  logic [edfs_pkg::IDX_W-1:0] pick;
  logic [TW-1:0]         best_key;

  always_comb begin
    now = restart ? '0 : current_time;
    for (int i = 0; i < N; i++) begin
      phase[i]  = restart ? '0 : release_phase[i];
      period[i] = (cfg.setup[i].period == '0) ? HW'(1) : cfg.setup[i].period;
      if (cfg.enable[i] && phase[i] == '0) begin
        bud[i] = cfg.setup[i].exec;
        dl[i]  = now + {{(TW-HW){1'b0}}, period[i]};
      end else begin
        bud[i] = budget_left[i];
        dl[i]  = job_deadline[i];
      end
      cand[i] = cfg.enable[i] && (bud[i] != '0);
      // signed distance to deadline, biased for an unsigned compare
      key[i]  = (dl[i] - now) ^ edfs_pkg::KEY_BIAS;
    end

    found    = 1'b0;
    pick     = '0;
    best_key = '0;
    for (int i = 0; i < N; i++) begin
      if (cand[i] && (!found || key[i] < best_key)) begin
        found    = 1'b1;
        best_key = key[i];
        pick     = edfs_pkg::IDX_W'(i);
      end
    end

    for (int i = 0; i < N; i++) begin
      budget_left_next[i]  = (found && pick == edfs_pkg::IDX_W'(i)) ? bud[i] - HW'(1) : bud[i];
      job_deadline_next[i] = dl[i];
      phase_inc[i]         = {1'b0, phase[i]} + (HW+1)'(1);
      release_phase_next[i] = (phase_inc[i] >= {1'b0, period[i]}) ? '0 : phase_inc[i][HW-1:0];
    end
    current_time_next = now + TW'(1);

    res.tick_time     = now;
    res.busy          = found;
    res.task_number   = found ? edfs_pkg::NUM_W'(pick) : '0;
    res.task_deadline = found ? dl[pick] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      for (int i = 0; i < N; i++) begin
        release_phase[i] <= '0;
        budget_left[i]   <= '0;
        job_deadline[i]  <= '0;
      end
    end else if (step) begin
      current_time <= current_time_next;
      for (int i = 0; i < N; i++) begin
        release_phase[i] <= release_phase_next[i];
        budget_left[i]   <= budget_left_next[i];
        job_deadline[i]  <= job_deadline_next[i];
      end
    end
  end

endmodule

// ----- src/edfs_skid.sv -----
// ----------------------------------------------------------------------------
// edfs_skid
// Result register with one skid entry; the input side stalls only while the
// skid entry is occupied.
// ----------------------------------------------------------------------------
module edfs_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  edfs_pkg::result_t res_in,
  input  logic              res_stall,
  output logic              res_valid,
  output edfs_pkg::result_t res_out,
  output logic              full
);

  logic              out_valid;
  logic              skid_valid;
  edfs_pkg::result_t out_data;
  edfs_pkg::result_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !res_stall) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else if (load) begin
          out_data <= res_in;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (load) begin
          out_data  <= res_in;
          out_valid <= 1'b1;
        end
      end else if (load) begin
        skid_data  <= res_in;
        skid_valid <= 1'b1;
      end
    end
  end

  assign res_valid = out_valid;
  assign res_out   = out_data;
  assign full      = skid_valid;

endmodule

// ----- src/edf_periodic_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler
// Earliest-deadline-first periodic task scheduler, one scheduler tick per
// transfer on the tick channel, one result per tick.
//
//   channel | signals                                   | direction
//   tick    | tick_valid, tick_stall, restart           | in
//   res     | res_valid, res_stall, tick_time, busy_res,| out
//           | task_number, task_deadline                |
//   cfg     | cfg_we, cfg_index, cfg_data               | in
//
// One tick per clock while tick_stall is low; its result is registered. Release,
// pick and state update are combinational between the task state registers
// and the result register.
// A one-entry skid buffer keeps ticks flowing while a result is stalled;
// tick_stall rises only when that entry is full.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  logic                            restart,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [edfs_pkg::TIME_W-1:0]     tick_time,
  output logic                            busy_res,
  output logic [edfs_pkg::NUM_W-1:0]      task_number,
  output logic [edfs_pkg::TIME_W-1:0]     task_deadline,
  input  logic                            cfg_we,
  input  logic [edfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edfs_pkg::CFG_DATA_W-1:0] cfg_data
);

  edfs_pkg::cfg_t    cfg;
  edfs_pkg::result_t res_comb;
  edfs_pkg::result_t res_reg;
  logic              step;
  logic              full;

  assign step       = tick_valid && !full;
  assign tick_stall = full;

  edfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  edfs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .restart (restart),
    .cfg     (cfg),
    .res     (res_comb)
  );

  edfs_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_comb),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_out   (res_reg),
    .full      (full)
  );

  assign tick_time     = res_reg.tick_time;
  assign busy_res      = res_reg.busy;
  assign task_number   = res_reg.task_number;
  assign task_deadline = res_reg.task_deadline;

endmodule

// ----- src/edfs_checker.sv -----
// ----------------------------------------------------------------------------
// edfs_checker
// Port-level checks for the EDF scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module edfs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            tick_valid,
  input logic                            tick_stall,
  input logic                            res_valid,
  input logic                            res_stall,
  input logic [edfs_pkg::TIME_W-1:0]     tick_time,
  input logic                            busy_res,
  input logic [edfs_pkg::NUM_W-1:0]      task_number,
  input logic [edfs_pkg::TIME_W-1:0]     task_deadline
);

  // input stalls only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> res_valid)
    else $error("tick_stall without pending result");

  a_no_stall_after_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |=> !tick_stall)
    else $error("tick_stall after empty result register");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> res_valid)
    else $error("tick transfer produced no result");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !busy_res) |-> (task_number == '0 && task_deadline == '0))
    else $error("idle result carries task data");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(tick_time) &&
                                  $stable(task_deadline) && $stable(busy_res)))
    else $error("stalled result changed");

endmodule

bind edf_periodic_task_scheduler edfs_checker u_edfs_checker (.*);

// ----- dv/edf_periodic_task_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_tb
// Self-checking bench for the EDF scheduler. Each accepted tick runs a local
// scheduler model; the block's results are checked in order against it.
// Directed cases cover reset, zero period, ties, task count edges, spare
// register indexes and a task disabled mid-job. Random phases follow, each
// with a fresh task setup, and random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_tb;

  localparam int REG_CNT   = int'(edfs_pkg::REG_ACTIVE_CNT);
  localparam int REG_SETUP = int'(edfs_pkg::REG_SETUP_FIRST);
  localparam int REG_SPARE = REG_SETUP + edfs_pkg::SETUP_REGS;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            tick_valid;
  logic                            tick_stall;
  logic                            restart;
  logic                            res_valid;
  logic                            res_stall;
  logic [edfs_pkg::TIME_W-1:0]     tick_time;
  logic                            busy_res;
  logic [edfs_pkg::NUM_W-1:0]      task_number;
  logic [edfs_pkg::TIME_W-1:0]     task_deadline;
  logic                            cfg_we;
  logic [edfs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [edfs_pkg::CFG_DATA_W-1:0] cfg_data;

  // scheduler model state
  logic [edfs_pkg::CNT_W-1:0]  cfg_count;
  edfs_pkg::setup_t            cfg_setup [edfs_pkg::TASK_SLOTS];
  logic [edfs_pkg::TIME_W-1:0] sched_now;
  logic [edfs_pkg::HALF_W-1:0] phase_cnt [edfs_pkg::TASK_SLOTS];
  logic [edfs_pkg::HALF_W-1:0] budget    [edfs_pkg::TASK_SLOTS];
  logic [edfs_pkg::TIME_W-1:0] job_dl    [edfs_pkg::TASK_SLOTS];

  edfs_pkg::result_t schedule_q [$];
  int                err_count;
  bit                gaps_on;

  edf_periodic_task_scheduler u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .restart      (restart),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .tick_time    (tick_time),
    .busy_res     (busy_res),
    .task_number  (task_number),
    .task_deadline(task_deadline),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [edfs_pkg::HALF_W:0] period_of(input int i);
    return (cfg_setup[i].period == '0) ? (edfs_pkg::HALF_W+1)'(1) :
                                         {1'b0, cfg_setup[i].period};
  endfunction

  function automatic edfs_pkg::result_t schedule_tick(input logic rs);
    edfs_pkg::result_t           r;
    int                          n_en;
    logic                        found;
    int                          pick;
    logic [edfs_pkg::TIME_W-1:0] best;
    logic [edfs_pkg::TIME_W-1:0] key;
    logic [edfs_pkg::HALF_W:0]   nx;
    n_en  = (cfg_count > edfs_pkg::TASK_SLOTS) ? edfs_pkg::TASK_SLOTS : int'(cfg_count);
    found = 1'b0;
    pick  = 0;
    best  = '0;
    if (rs) begin
      sched_now = '0;
      for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) phase_cnt[i] = '0;
    end
    for (int i = 0; i < n_en; i++) begin
      if (phase_cnt[i] == '0) begin
        budget[i] = cfg_setup[i].exec;
        job_dl[i] = sched_now + edfs_pkg::TIME_W'(period_of(i));
      end
    end
    // signed distance to deadline, biased so an unsigned compare orders it
    for (int i = 0; i < n_en; i++) begin
      if (budget[i] != '0) begin
        key = (job_dl[i] - sched_now) ^ edfs_pkg::KEY_BIAS;
        if (!found || key < best) begin
          found = 1'b1;
          best  = key;
          pick  = i;
        end
      end
    end
    r.tick_time = sched_now;
    if (found) begin
      budget[pick]    = budget[pick] - edfs_pkg::HALF_W'(1);
      r.busy          = 1'b1;
      r.task_number   = pick[edfs_pkg::NUM_W-1:0];
      r.task_deadline = job_dl[pick];
    end else begin
      r.busy          = 1'b0;
      r.task_number   = '0;
      r.task_deadline = '0;
    end
    for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) begin
      nx = {1'b0, phase_cnt[i]} + (edfs_pkg::HALF_W+1)'(1);
      phase_cnt[i] = (nx >= period_of(i)) ? '0 : nx[edfs_pkg::HALF_W-1:0];
    end
    sched_now = sched_now + edfs_pkg::TIME_W'(1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  always @(negedge clk) res_stall <= gaps_on && ($urandom_range(99) < 36);

  always @(posedge clk) begin : check_results
    edfs_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (schedule_q.size() == 0) begin
        report_mismatch("unexpected result transfer", tick_time, 32'd0);
      end else begin
        want = schedule_q.pop_front();
        if (tick_time !== want.tick_time)
          report_mismatch("tick_time", tick_time, want.tick_time);
        if (busy_res !== want.busy)
          report_mismatch("busy_res", 32'(busy_res), 32'(want.busy));
        if (task_number !== want.task_number)
          report_mismatch("task_number", 32'(task_number), 32'(want.task_number));
        if (task_deadline !== want.task_deadline)
          report_mismatch("task_deadline", task_deadline, want.task_deadline);
      end
    end
  end

  // called at a falling edge; leaves tick_valid high after the transfer
  task automatic send_tick(input logic rs);
    while (gaps_on && $urandom_range(99) < 36) begin
      tick_valid <= 1'b0;
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (tick_stall);
    schedule_q.push_back(schedule_tick(rs));
    @(negedge clk);
  endtask

  task automatic drain_results();
    tick_valid <= 1'b0;
    while (schedule_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input int idx,
                           input logic [edfs_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= edfs_pkg::CFG_IDX_W'(idx);
    cfg_data  <= data;
    if (idx == REG_CNT)
      cfg_count = data[edfs_pkg::CNT_W-1:0];
    else if (idx >= REG_SETUP && idx < REG_SPARE)
      cfg_setup[idx - REG_SETUP] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input int restart_pct);
    for (int k = 0; k < n; k++) send_tick($urandom_range(99) < restart_pct);
  endtask

  function automatic logic [edfs_pkg::CFG_DATA_W-1:0] rand_setup();
    edfs_pkg::setup_t s;
    case ($urandom_range(19))
      0:       s.period = '0;
      1:       s.period = '1;
      2:       s.period = edfs_pkg::HALF_W'($urandom());
      default: s.period = edfs_pkg::HALF_W'($urandom_range(1, 12));
    endcase
    case ($urandom_range(19))
      0:       s.exec = '0;
      1:       s.exec = '1;
      2:       s.exec = edfs_pkg::HALF_W'($urandom());
      default: s.exec = edfs_pkg::HALF_W'($urandom_range(0, 8));
    endcase
    return s;
  endfunction

  // defaults: one task with no execution time, so every tick is idle
  task automatic test_reset_state();
    run_ticks(3, 0);
    drain_results();
  endtask

  task automatic test_zero_period_and_ties();
    write_reg(REG_CNT, 32'd2);
    write_reg(REG_SETUP, {16'd0, 16'd2});
    write_reg(REG_SETUP + 1, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(REG_SPARE + 2, 32'hFFFF_FFFF);
    send_tick(1'b1);
    run_ticks(3, 0);
    drain_results();
    // equal deadlines: lower task number wins
    write_reg(REG_SETUP, {16'd4, 16'd2});
    write_reg(REG_SETUP + 1, {16'd4, 16'd3});
    send_tick(1'b1);
    run_ticks(3, 0);
    drain_results();
  endtask

  task automatic test_task_count_edges();
    write_reg(REG_CNT, 32'd7);
    write_reg(REG_SETUP + 2, {16'd2, 16'd1});
    write_reg(REG_SETUP + 3, {16'd2, 16'd1});
    send_tick(1'b1);
    run_ticks(3, 0);
    drain_results();
    write_reg(REG_CNT, 32'd0);
    run_ticks(2, 0);
    drain_results();
  endtask

  // disable task 1 while its job is pending, then bring it back with that job still pending
  task automatic test_overdue();
    write_reg(REG_CNT, 32'd2);
    write_reg(REG_SETUP, {16'd3, 16'd3});
    write_reg(REG_SETUP + 1, {16'd6, 16'd4});
    send_tick(1'b1);
    run_ticks(1, 0);
    drain_results();
    write_reg(REG_CNT, 32'd1);
    run_ticks(3, 0);
    drain_results();
    write_reg(REG_CNT, 32'd2);
    run_ticks(3, 0);
    drain_results();
  endtask

  task automatic test_random();
    int n_sent;
    int phase_no;
    n_sent   = 0;
    phase_no = 0;
    while (n_sent < 1030) begin
      int len;
      gaps_on = !(phase_no >= 8 && phase_no < 11);
      if ($urandom_range(3) == 0)
        write_reg(REG_CNT, $urandom_range(7));
      else
        write_reg(REG_CNT, $urandom_range(1, 4));
      for (int i = 0; i < edfs_pkg::SETUP_REGS; i++)
        if ($urandom_range(3) != 0) write_reg(REG_SETUP + i, rand_setup());
      if ($urandom_range(7) == 0)
        write_reg(REG_SPARE + int'($urandom_range(2)), $urandom());
      len = int'($urandom_range(20, 60));
      send_tick($urandom_range(1) == 1);
      run_ticks(len - 1, 3);
      drain_results();
      n_sent += len;
      phase_no++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    tick_valid = 1'b0;
    restart    = 1'b0;
    res_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    err_count  = 0;
    cfg_count  = edfs_pkg::ACTIVE_CNT_RESET;
    sched_now  = '0;
    for (int i = 0; i < edfs_pkg::TASK_SLOTS; i++) begin
      cfg_setup[i] = {edfs_pkg::PERIOD_RESET, 16'd0};
      phase_cnt[i] = '0;
      budget[i]    = '0;
      job_dl[i]    = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_zero_period_and_ties();
    test_task_count_edges();
    test_overdue();
    test_random();
    drain_results();
    if (err_count == 0) begin
      $display("edf_periodic_task_scheduler_tb: clean");
    end else begin
      $display("edf_periodic_task_scheduler_tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("edf_periodic_task_scheduler_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/edfs_pkg.sv
src/edfs_cfg.sv
src/edfs_core.sv
src/edfs_skid.sv
src/edf_periodic_task_scheduler.sv
src/edfs_checker.sv
dv/edf_periodic_task_scheduler_tb.sv
